// File: rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg: shared types and constants of the signal frame packer
// request and result structs, error codes, register indexes, datapath widths
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfp_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 8;
  localparam int FRAME_BITS  = 64;

  // datapath widths
  localparam int DIFF_W     = 49;  // value minus offset, signed
  localparam int SCALE_W    = 32;  // magnitude of the scale
  localparam int DIVIDEND_W = 50;  // 2|diff| + |scale|
  localparam int DIVISOR_W  = 33;  // 2|scale|
  localparam int QUOT_W     = 49;  // rounded quotient magnitude
  localparam int RAW_W      = 50;  // signed raw value
  localparam int CNT_W      = $clog2(DIVIDEND_W);

  // configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int ID_BITS_W = 5;
  localparam logic [ID_BITS_W-1:0] ID_BITS_RESET = ID_BITS_W'(8);

  localparam logic REG_NODE_ID_BITS = 1'b0;
  localparam logic REG_MSG_NUM_BITS = 1'b1;

  // error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_DEVICE_ID    = 3'd1;
  localparam logic [2:0] ERR_MESSAGE_ID   = 3'd2;
  localparam logic [2:0] ERR_SIGNED_RANGE = 3'd3;
  localparam logic [2:0] ERR_NEGATIVE     = 3'd4;
  localparam logic [2:0] ERR_UNSIGNED_RNG = 3'd5;
  localparam logic [2:0] ERR_ZERO_SCALE   = 3'd6;
  localparam logic [2:0] ERR_OVERFLOW     = 3'd7;

  typedef struct packed {
    logic [31:0]        node_id;
    logic [31:0]        msg_num;
    logic [3:0]         frame_length;
    logic [5:0]         start_bit;
    logic [6:0]         bit_length;
    logic               is_signed;
    logic signed [47:0] physical_value;
    logic signed [47:0] signal_offset;
    logic signed [31:0] signal_scale;
    logic               last_signal;
  } sig_t;

  typedef struct packed {
    logic [31:0] frame_id;
    logic [3:0]  frame_dlc;
    logic [63:0] frame_payload;
    logic [2:0]  error_code;
  } frame_t;

endpackage

// File: rtl/sfp_div.sv
// ----------------------------------------------------------------------------
// sfp_div: iterative unsigned divider
// restoring division, one quotient bit per cycle through one shared subtractor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfp_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [sfp_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [sfp_pkg::DIVISOR_W-1:0]    divisor,
  output logic                             done,
  output logic [sfp_pkg::QUOT_W-1:0]       quotient
);

  logic                               busy;
  logic [sfp_pkg::CNT_W-1:0]          count;
  logic [sfp_pkg::DIVIDEND_W-1:0]     work;
  logic [sfp_pkg::DIVISOR_W-1:0]      rem;
  logic [sfp_pkg::DIVISOR_W-1:0]      dvsr;
  logic [sfp_pkg::DIVISOR_W:0]        trial;
  logic [sfp_pkg::DIVISOR_W:0]        trial_sub;
  logic                               qbit;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial     = {rem, work[sfp_pkg::DIVIDEND_W-1]};
    trial_sub = trial - {1'b0, dvsr};
    qbit      = ~trial_sub[sfp_pkg::DIVISOR_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == sfp_pkg::CNT_W'(sfp_pkg::DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      dvsr <= divisor;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[sfp_pkg::DIVIDEND_W-2:0], qbit};
      rem  <= qbit ? trial_sub[sfp_pkg::DIVISOR_W-1:0] : trial[sfp_pkg::DIVISOR_W-1:0];
    end
  end

  assign quotient = work[sfp_pkg::QUOT_W-1:0];

  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    start |=> busy && count == '0)
    else $error("divider did not start");

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("divider done without a finished run");

endmodule

// File: rtl/sfp_pack.sv
// ----------------------------------------------------------------------------
// sfp_pack: range check and bit insertion
// signs the quotient, checks it against the signal width, merges it into the frame
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfp_pack (
  input  logic [sfp_pkg::FRAME_BITS-1:0] frame_bits,
  input  logic [sfp_pkg::QUOT_W-1:0]     quot,
  input  logic                           neg,
  input  logic [5:0]                     start_bit,
  input  logic [6:0]                     bit_length,
  input  logic                           is_signed,
  output logic [2:0]                     range_err,
  output logic [sfp_pkg::FRAME_BITS-1:0] frame_next
);

  logic [sfp_pkg::RAW_W-1:0]        raw;
  logic [sfp_pkg::RAW_W-1:0]        raw_sh;
  logic [sfp_pkg::FRAME_BITS-1:0]   raw_ext;
  logic [sfp_pkg::FRAME_BITS-1:0]   mask;
  logic [5:0]                       shamt;
  logic                             narrow;

  always_comb begin
    raw     = neg ? -{1'b0, quot} : {1'b0, quot};
    raw_ext = {{(sfp_pkg::FRAME_BITS - sfp_pkg::RAW_W){raw[sfp_pkg::RAW_W-1]}}, raw};
    // widths below the raw width need an explicit check
    narrow  = bit_length < 7'(sfp_pkg::RAW_W);
    shamt   = 6'(bit_length - 7'd1);
    raw_sh  = '0;
    range_err = sfp_pkg::ERR_NONE;
    if (is_signed) begin
      raw_sh = $unsigned($signed(raw) >>> shamt);
      if (narrow && !((raw_sh == '0) || (raw_sh == '1))) begin
        range_err = sfp_pkg::ERR_SIGNED_RANGE;
      end
    end else begin
      raw_sh = raw >> bit_length[5:0];
      if (raw[sfp_pkg::RAW_W-1]) begin
        range_err = sfp_pkg::ERR_NEGATIVE;
      end else if (narrow && raw_sh != '0) begin
        range_err = sfp_pkg::ERR_UNSIGNED_RNG;
      end
    end

    if (bit_length >= 7'(sfp_pkg::FRAME_BITS)) begin
      mask = '1;
    end else begin
      mask = (sfp_pkg::FRAME_BITS'(1) << bit_length) - sfp_pkg::FRAME_BITS'(1);
    end
    frame_next = (frame_bits & ~(mask << start_bit)) | ((raw_ext & mask) << start_bit);
  end

endmodule

// File: rtl/signal_frame_packer.sv
// ----------------------------------------------------------------------------
// signal_frame_packer: scales signals and packs them into a data frame
// per request: raw = round((value - offset) / scale), range check, insert bits
// ----------------------------------------------------------------------------
// usage
//   sig channel (sig_valid / sig_ready / sig): one signal per request. the
//   request with last_signal set closes the frame and produces one result on
//   the frame channel (frame_valid / frame_ready / frame); other requests
//   produce nothing.
//   apb port: register 0 at 0x0 is the node id width, register 1 at 0x4 is
//   the message number width, both 5 bits, read back in the low bits of prdata.
//   sequence: one request at a time; after the accept the request passes
//   the setup states (diff, abs, sum), the divider (50 restoring steps,
//   one quotient bit each, then the report of done) and the merge state.
//   a request rejected by the id, length or zero scale checks skips the
//   divide. the next request is taken only once the merge is committed.
//   output: the frame is written into the output register in the merge
//   state of the last request, whether or not that request divides.
//   stall: the result waits in the output register while new requests are
//   taken; a further last request holds in its merge cycle until the
//   pending frame is taken.
//   reset: both width registers return to 8, the frame and the error code
//   clear, no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signal_frame_packer (
  input  logic                          clk,
  input  logic                          rst,
  // signal requests
  input  logic                          sig_valid,
  output logic                          sig_ready,
  input  sfp_pkg::sig_t                 sig,
  // finished frames
  output logic                          frame_valid,
  input  logic                          frame_ready,
  output sfp_pkg::frame_t               frame,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfp_pkg::PADDR_W-1:0]   paddr,
  input  logic [sfp_pkg::PDATA_W-1:0]   pwdata,
  output logic [sfp_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIFF   = 6'b000010,
    S_ABS    = 6'b000100,
    S_SUM    = 6'b001000,
    S_DIV    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t                               state;
  state_t                               state_next;
  sfp_pkg::sig_t                        req;

  // configuration registers
  logic [sfp_pkg::ID_BITS_W-1:0]        dev_bits;
  logic [sfp_pkg::ID_BITS_W-1:0]        msg_bits;
  logic                                 reg_idx;

  // arithmetic registers
  logic signed [sfp_pkg::DIFF_W-1:0]    diff;
  logic [sfp_pkg::DIFF_W-1:0]           abs_diff;
  logic [sfp_pkg::SCALE_W-1:0]          abs_scale;
  logic                                 neg;
  logic [2:0]                           pre_err;
  logic [2:0]                           pre_err_next;

  // frame state
  logic [sfp_pkg::FRAME_BITS-1:0]       frame_bits;
  logic [2:0]                           first_error;

  // divider
  logic                                 div_start;
  logic                                 div_done;
  logic [sfp_pkg::DIVIDEND_W-1:0]       dividend;
  logic [sfp_pkg::DIVISOR_W-1:0]        divisor;
  logic [sfp_pkg::QUOT_W-1:0]           quot;

  // pack unit
  logic [2:0]                           range_err;
  logic [sfp_pkg::FRAME_BITS-1:0]       frame_merged;

  // merge cycle
  logic [2:0]                           item_err;
  logic [2:0]                           first_error_next;
  logic [sfp_pkg::FRAME_BITS-1:0]       frame_bits_next;
  logic                                 commit;
  logic                                 emit;
  logic [7:0]                           end_bit;

  // --------------------------------------------------------------------------
  // register port: always ready, word addressed
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[sfp_pkg::PADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_bits <= sfp_pkg::ID_BITS_RESET;
      msg_bits <= sfp_pkg::ID_BITS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        sfp_pkg::REG_NODE_ID_BITS: dev_bits <= pwdata[sfp_pkg::ID_BITS_W-1:0];
        sfp_pkg::REG_MSG_NUM_BITS: msg_bits <= pwdata[sfp_pkg::ID_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sfp_pkg::REG_NODE_ID_BITS:
        prdata = sfp_pkg::PDATA_W'(dev_bits);
      sfp_pkg::REG_MSG_NUM_BITS:
        prdata = sfp_pkg::PDATA_W'(msg_bits);
      default:
        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // early checks, in priority order: device id, message id, bit span, scale
  // --------------------------------------------------------------------------
  assign end_bit = {2'b00, req.start_bit} + {1'b0, req.bit_length};

  always_comb begin
    if ((req.node_id >> dev_bits) != '0) begin
      pre_err_next = sfp_pkg::ERR_DEVICE_ID;
    end else if ((req.msg_num >> msg_bits) != '0) begin
      pre_err_next = sfp_pkg::ERR_MESSAGE_ID;
    end else if (req.bit_length == '0 || end_bit > 8'(sfp_pkg::FRAME_BYTES * 8)) begin
      pre_err_next = sfp_pkg::ERR_OVERFLOW;
    end else if (req.signal_scale == '0) begin
      pre_err_next = sfp_pkg::ERR_ZERO_SCALE;
    end else begin
      pre_err_next = sfp_pkg::ERR_NONE;
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign sig_ready = (state == S_IDLE);
  assign commit    = (state == S_FINISH) &&
                     (!req.last_signal || !frame_valid || frame_ready);
  assign emit      = commit && req.last_signal;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (sig_valid) state_next = S_DIFF;
      S_DIFF:   state_next = S_ABS;
      S_ABS:    state_next = (pre_err != sfp_pkg::ERR_NONE) ? S_FINISH : S_SUM;
      S_SUM:    state_next = S_DIV;
      S_DIV:    if (div_done) state_next = S_FINISH;
      S_FINISH: if (commit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  function automatic logic signed [sfp_pkg::DIFF_W-1:0] DIFF_W_EXT(
    input logic signed [47:0] v
  );
    DIFF_W_EXT = {v[47], v};
  endfunction

  // request capture and operand preparation, one wide add per cycle
  always_ff @(posedge clk) begin
    if (sig_valid && sig_ready) begin
      req <= sig;
    end
    if (state == S_DIFF) begin
      diff      <= DIFF_W_EXT(req.physical_value) - DIFF_W_EXT(req.signal_offset);
      abs_scale <= req.signal_scale[sfp_pkg::SCALE_W-1] ? -req.signal_scale
                                                        : req.signal_scale;
      pre_err   <= pre_err_next;
    end
    if (state == S_ABS) begin
      abs_diff <= diff[sfp_pkg::DIFF_W-1] ? -diff : diff;
      neg      <= diff[sfp_pkg::DIFF_W-1] ^ req.signal_scale[sfp_pkg::SCALE_W-1];
    end
  end

  // rounding: (2|diff| + |scale|) / (2|scale|), halves away from zero
  assign div_start = (state == S_SUM);
  assign dividend  = {abs_diff, 1'b0} + sfp_pkg::DIVIDEND_W'(abs_scale);
  assign divisor   = {1'b0, abs_scale} << 1;

  sfp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quot)
  );

  sfp_pack u_pack (
    .frame_bits (frame_bits),
    .quot       (quot),
    .neg        (neg),
    .start_bit  (req.start_bit),
    .bit_length (req.bit_length),
    .is_signed  (req.is_signed),
    .range_err  (range_err),
    .frame_next (frame_merged)
  );

  // --------------------------------------------------------------------------
  // merge cycle: a failing signal leaves the frame alone, first error sticks
  // --------------------------------------------------------------------------
  always_comb begin
    item_err         = (pre_err != sfp_pkg::ERR_NONE) ? pre_err : range_err;
    frame_bits_next  = (item_err == sfp_pkg::ERR_NONE) ? frame_merged : frame_bits;
    first_error_next = (first_error == sfp_pkg::ERR_NONE) ? item_err : first_error;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits  <= '0;
      first_error <= sfp_pkg::ERR_NONE;
      frame_valid <= 1'b0;
    end else begin
      if (emit) begin
        frame_bits  <= '0;
        first_error <= sfp_pkg::ERR_NONE;
        frame_valid <= 1'b1;
      end else begin
        if (commit) begin
          frame_bits  <= frame_bits_next;
          first_error <= first_error_next;
        end
        if (frame_ready) begin
          frame_valid <= 1'b0;
        end
      end
    end
  end

  // output register, loaded only when the previous frame is gone or leaving
  always_ff @(posedge clk) begin
    if (emit) begin
      frame.frame_id      <= (req.node_id << msg_bits) | req.msg_num;
      frame.frame_dlc     <= req.frame_length;
      frame.frame_payload <= frame_bits_next;
      frame.error_code    <= first_error_next;
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_done_in_div : assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_clear_after_emit : assert property (@(posedge clk) disable iff (rst)
    emit |=> frame_bits == '0 && first_error == sfp_pkg::ERR_NONE)
    else $error("frame not cleared after emit");

  a_sticky_error : assert property (@(posedge clk) disable iff (rst)
    first_error != sfp_pkg::ERR_NONE && !emit |=> first_error == $past(first_error))
    else $error("first error overwritten inside a frame");

  a_emit_loads : assert property (@(posedge clk) disable iff (rst)
    emit |=> frame_valid)
    else $error("emitted frame not presented");

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking regression for the signal frame packer
// drives signal requests and register writes, folds every accepted request
// into a local copy of the frame state, and compares each finished frame
// field by field with the oldest frame still due
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // timing of the run
  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 80;    // one full divide plus margin
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int STALL_LIMIT  = 3000;  // cycles with no handshake or register access
  localparam int PRINT_LIMIT  = 40;
  localparam longint ONE      = 64'sd65536;  // 1.0 in 16 fraction bits

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          sig_valid = 1'b0;
  logic                          sig_ready;
  sfp_pkg::sig_t                 sig = '0;
  logic                          frame_valid;
  logic                          frame_ready = 1'b0;
  sfp_pkg::frame_t               frame;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [sfp_pkg::PADDR_W-1:0]   paddr = '0;
  logic [sfp_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [sfp_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  // local copy of the block state and its width registers
  logic [63:0]                   frame_acc = '0;
  logic [2:0]                    frame_err = sfp_pkg::ERR_NONE;
  logic [sfp_pkg::ID_BITS_W-1:0] cfg_dev_bits = sfp_pkg::ID_BITS_RESET;
  logic [sfp_pkg::ID_BITS_W-1:0] cfg_msg_bits = sfp_pkg::ID_BITS_RESET;

  // frames owed by the block, oldest first
  sfp_pkg::frame_t               frames_due[$];

  int                            mismatch_count = 0;
  int                            idle_cycles = 0;
  int                            tx_gap_max = 0;
  int                            rx_gap_max = 0;
  int                            rx_hold_cycles = 0;

  signal_frame_packer dut (
    .clk         (clk),
    .rst         (rst),
    .sig_valid   (sig_valid),
    .sig_ready   (sig_ready),
    .sig         (sig),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  // fold one accepted request into the frame; a closing request owes a frame
  task automatic pack_signal(sfp_pkg::sig_t s);
    logic [2:0]      code;
    int              start_pos;
    int              len;
    longint          diff;
    longint          scl;
    longint          raw;
    longint          lim;
    longint unsigned diff_mag;
    longint unsigned scale_mag;
    longint unsigned quot;
    logic [63:0]     mask;
    sfp_pkg::frame_t done_frame;
    start_pos = s.start_bit;
    len       = s.bit_length;
    code      = sfp_pkg::ERR_NONE;
    diff      = longint'($signed(s.physical_value)) - longint'($signed(s.signal_offset));
    scl       = longint'($signed(s.signal_scale));
    // check order: device id, message id, bit overflow, zero scale, range
    if ((s.node_id >> cfg_dev_bits) != 0) begin
      code = sfp_pkg::ERR_DEVICE_ID;
    end else if ((s.msg_num >> cfg_msg_bits) != 0) begin
      code = sfp_pkg::ERR_MESSAGE_ID;
    end else if (len == 0 || start_pos + len > sfp_pkg::FRAME_BITS) begin
      code = sfp_pkg::ERR_OVERFLOW;
    end else if (scl == 0) begin
      code = sfp_pkg::ERR_ZERO_SCALE;
    end else begin
      if (diff < 0) diff_mag = -diff;
      else diff_mag = diff;
      if (scl < 0) scale_mag = -scl;
      else scale_mag = scl;
      // halves round away from zero
      quot = (2 * diff_mag + scale_mag) / (2 * scale_mag);
      raw  = ((diff < 0) != (scl < 0)) ? -longint'(quot) : longint'(quot);
      if (s.is_signed) begin
        if (len < 64) begin
          lim = longint'(64'd1 << (len - 1));
          if (raw < -lim || raw > lim - 1) code = sfp_pkg::ERR_SIGNED_RANGE;
        end
      end else if (raw < 0) begin
        code = sfp_pkg::ERR_NEGATIVE;
      end else if (len < 64 && raw > longint'((64'd1 << len) - 64'd1)) begin
        code = sfp_pkg::ERR_UNSIGNED_RNG;
      end
      // a failing signal leaves the frame untouched
      if (code == sfp_pkg::ERR_NONE) begin
        mask = (len >= 64) ? '1 : (64'd1 << len) - 64'd1;
        frame_acc = (frame_acc & ~(mask << start_pos)) | ((64'(raw) & mask) << start_pos);
      end
    end
    if (frame_err == sfp_pkg::ERR_NONE) frame_err = code;
    if (s.last_signal) begin
      done_frame.frame_id      = (s.node_id << cfg_msg_bits) | s.msg_num;
      done_frame.frame_dlc     = s.frame_length;
      done_frame.frame_payload = frame_acc;
      done_frame.error_code    = frame_err;
      frames_due.push_back(done_frame);
      frame_acc = '0;
      frame_err = sfp_pkg::ERR_NONE;
    end
  endtask

  // offer one request after a random gap, hold it until accepted
  task automatic send_signal(sfp_pkg::sig_t s);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      sig_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sig       <= s;
    sig_valid <= 1'b1;
    do @(posedge clk); while (!(sig_valid && sig_ready));
    pack_signal(s);
  endtask

  // drop valid, let every owed frame arrive, then let a silent divide finish
  task automatic wait_idle();
    sig_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register access: setup cycle, then access cycle
  task automatic apb_access(bit wr, logic idx, logic [sfp_pkg::PDATA_W-1:0] wdata,
                            output logic [sfp_pkg::PDATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= sfp_pkg::PADDR_W'(idx) << 2;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // reprogram both id widths while idle and read them back
  task automatic set_id_widths(int dev_bits, int msg_bits);
    logic [sfp_pkg::PDATA_W-1:0] rd;
    wait_idle();
    // upper data bits are junk, only the low five bits count
    apb_access(1'b1, sfp_pkg::REG_NODE_ID_BITS,
               ($urandom & ~32'h1F) | sfp_pkg::PDATA_W'(dev_bits), rd);
    cfg_dev_bits = sfp_pkg::ID_BITS_W'(dev_bits);
    apb_access(1'b1, sfp_pkg::REG_MSG_NUM_BITS,
               ($urandom & ~32'h1F) | sfp_pkg::PDATA_W'(msg_bits), rd);
    cfg_msg_bits = sfp_pkg::ID_BITS_W'(msg_bits);
    apb_access(1'b0, sfp_pkg::REG_NODE_ID_BITS, '0, rd);
    if (rd[sfp_pkg::ID_BITS_W-1:0] !== cfg_dev_bits) begin
      report_mismatch($sformatf("node id width read %0d want %0d", rd[4:0], cfg_dev_bits));
    end
    apb_access(1'b0, sfp_pkg::REG_MSG_NUM_BITS, '0, rd);
    if (rd[sfp_pkg::ID_BITS_W-1:0] !== cfg_msg_bits) begin
      report_mismatch($sformatf("msg number width read %0d want %0d", rd[4:0], cfg_msg_bits));
    end
  endtask

  function automatic sfp_pkg::sig_t make_sig(logic [31:0] dev, logic [31:0] msg, int dlc,
                                             int start_pos, int len, bit sgn, longint val,
                                             longint off, longint scl, bit last);
    sfp_pkg::sig_t s;
    s.node_id        = dev;
    s.msg_num        = msg;
    s.frame_length   = 4'(dlc);
    s.start_bit      = 6'(start_pos);
    s.bit_length     = 7'(len);
    s.is_signed      = sgn;
    s.physical_value = val[47:0];
    s.signal_offset  = off[47:0];
    s.signal_scale   = scl[31:0];
    s.last_signal    = last;
    return s;
  endfunction

  // mostly well-formed signal: ids fit, bits fit, raw chosen first and the
  // value built from it; a fifth of the requests get junk in some fields
  function automatic sfp_pkg::sig_t random_signal(bit last);
    sfp_pkg::sig_t   s;
    int              len;
    int              start_pos;
    int              scale_exp;
    int              r_bits;
    logic [31:0]     mag;
    longint unsigned bits;
    longint          r;
    longint          scl;
    longint          off;
    longint          val;
    longint          nudge;
    s.node_id      = $urandom & 32'((64'd1 << cfg_dev_bits) - 64'd1);
    s.msg_num      = $urandom & 32'((64'd1 << cfg_msg_bits) - 64'd1);
    s.frame_length = 4'($urandom_range(0, 15));
    len            = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 64 : 16);
    start_pos      = $urandom_range(0, sfp_pkg::FRAME_BITS - len);
    s.start_bit    = 6'(start_pos);
    s.bit_length   = 7'(len);
    s.is_signed    = 1'($urandom_range(0, 1));
    scale_exp      = $urandom_range(0, ($urandom_range(0, 1) == 0) ? 16 : 30);
    mag            = $urandom_range(1, (32'd1 << (scale_exp + 1)) - 1);
    scl            = ($urandom_range(0, 1) == 1) ? -longint'(mag) : longint'(mag);
    // keep raw * scale inside the 48-bit value
    r_bits = len;
    if (r_bits > 30) r_bits = 30;
    if (r_bits > 45 - scale_exp) r_bits = 45 - scale_exp;
    bits = {$urandom, $urandom} & ((64'd1 << r_bits) - 64'd1);
    if (s.is_signed && bits[r_bits-1]) r = longint'(bits) - longint'(64'd1 << r_bits);
    else r = longint'(bits);
    // now and then one step outside the legal range
    if (len <= 29 && $urandom_range(0, 9) == 0) begin
      if (!s.is_signed) r = ($urandom_range(0, 1) == 0) ? -1 : longint'(64'd1 << len);
      else if (r < 0) r = -longint'(64'd1 << (len - 1)) - 1;
      else r = longint'(64'd1 << (len - 1));
    end
    // fraction: none, an exact half, or anything below a half
    case ($urandom_range(0, 2))
      0:       nudge = 0;
      1:       nudge = longint'(mag / 2);
      default: nudge = longint'($urandom_range(0, mag / 2));
    endcase
    if ($urandom_range(0, 1) == 1) nudge = -nudge;
    bits = {$urandom, $urandom};
    off  = longint'(bits << 18) >>> 18;
    val  = off + r * scl + nudge;
    s.physical_value = val[47:0];
    s.signal_offset  = off[47:0];
    s.signal_scale   = scl[31:0];
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 2) == 0) s.node_id = $urandom;
      if ($urandom_range(0, 2) == 0) s.msg_num = $urandom;
      if ($urandom_range(0, 2) == 0) s.start_bit = 6'($urandom);
      if ($urandom_range(0, 2) == 0) s.bit_length = 7'($urandom);
      if ($urandom_range(0, 2) == 0) s.physical_value = 48'({$urandom, $urandom});
      if ($urandom_range(0, 2) == 0) s.signal_offset = 48'({$urandom, $urandom});
      if ($urandom_range(0, 2) == 0) s.signal_scale = $urandom;
      if ($urandom_range(0, 3) == 0) s.signal_scale = '0;
    end
    s.last_signal = last;
    return s;
  endfunction

  // hand-picked frames: rounding, signs, every error code, field extremes
  task automatic test_directed();
    longint maxv;
    longint minv;
    maxv = 64'sd140737488355327;
    minv = -64'sd140737488355328;
    tx_gap_max = 3;
    rx_gap_max = 3;
    // plain packing, halves away from zero, negative scale, dlc above eight
    send_signal(make_sig(5, 3, 8, 0, 8, 0, 200 * ONE, 0, ONE, 0));
    send_signal(make_sig(5, 3, 8, 8, 8, 1, -3 * ONE, 0, ONE, 0));
    send_signal(make_sig(5, 3, 8, 16, 4, 0, 3, 0, 2, 0));
    send_signal(make_sig(5, 3, 8, 20, 4, 1, -3, 0, 2, 0));
    send_signal(make_sig(5, 3, 8, 24, 8, 1, 5, 0, -2, 0));
    send_signal(make_sig(5, 3, 15, 56, 8, 0, 300 * ONE, 45 * ONE, ONE, 1));
    // device id and message id out of range, frame id still formed
    send_signal(make_sig(256, 3, 4, 0, 8, 0, ONE, 0, ONE, 1));
    send_signal(make_sig(5, 32'hFFFF_FFFF, 4, 0, 8, 0, ONE, 0, ONE, 1));
    // zero length, then a signal running past bit 63 after a good top bit
    send_signal(make_sig(5, 3, 2, 0, 0, 0, ONE, 0, ONE, 1));
    send_signal(make_sig(5, 3, 8, 63, 1, 0, ONE, 0, ONE, 0));
    send_signal(make_sig(5, 3, 8, 60, 5, 0, ONE, 0, ONE, 1));
    // zero scale
    send_signal(make_sig(5, 3, 8, 0, 8, 0, ONE, 0, 0, 1));
    // largest scale, then a signed value one past the top
    send_signal(make_sig(0, 0, 0, 8, 18, 1, maxv, 0, 32'sh7FFF_FFFF, 0));
    send_signal(make_sig(0, 0, 0, 0, 4, 1, 8 * ONE, 0, ONE, 1));
    // negative value on an unsigned signal, largest legal ids
    send_signal(make_sig(255, 255, 1, 0, 8, 0, -ONE, 0, ONE, 1));
    // overlap clears bits, then an unsigned overflow is not written
    send_signal(make_sig(1, 1, 8, 0, 16, 0, 65535 * ONE, 0, ONE, 0));
    send_signal(make_sig(1, 1, 8, 4, 4, 0, 0, 0, ONE, 0));
    send_signal(make_sig(1, 1, 8, 16, 4, 0, 16 * ONE, 0, ONE, 1));
    // full 64-bit signals at the value, offset and scale extremes
    send_signal(make_sig(0, 0, 8, 0, 64, 1, maxv, minv, 1, 1));
    send_signal(make_sig(2, 2, 8, 0, 64, 0, minv, maxv, -64'sd2147483648, 1));
    wait_idle();
  endtask

  // id widths at both ends, ids on either side of each limit
  task automatic test_id_widths();
    int            dev_w[5] = '{0, 31, 0, 31, 3};
    int            msg_w[5] = '{0, 31, 31, 0, 17};
    logic [31:0]   dev_max;
    logic [31:0]   msg_max;
    sfp_pkg::sig_t s;
    tx_gap_max = 6;
    rx_gap_max = 6;
    for (int i = 0; i < 5; i++) begin
      set_id_widths(dev_w[i], msg_w[i]);
      dev_max = 32'((64'd1 << dev_w[i]) - 64'd1);
      msg_max = 32'((64'd1 << msg_w[i]) - 64'd1);
      for (int k = 0; k < 4; k++) begin
        s = random_signal(1'b1);
        s.node_id = (k == 1) ? dev_max + 1 : (k == 3) ? '1 : dev_max;
        s.msg_num = (k == 2) ? msg_max + 1 : (k == 3) ? '1 : msg_max;
        send_signal(s);
      end
    end
  endtask

  // frames of one to six signals under changing widths and idling
  task automatic test_random();
    int n_sig;
    int sent;
    for (int chunk = 0; chunk < 8; chunk++) begin
      case (chunk)
        0:       set_id_widths(8, 8);
        1:       set_id_widths(31, 31);
        2:       set_id_widths(0, 0);
        default: set_id_widths($urandom_range(0, 31), $urandom_range(0, 31));
      endcase
      // cover both sides idling, neither, and each alone
      tx_gap_max = chunk[0] ? 12 : 0;
      rx_gap_max = chunk[1] ? 12 : 0;
      sent = 0;
      while (sent < 85) begin
        n_sig = $urandom_range(1, 6);
        for (int i = 0; i < n_sig; i++) send_signal(random_signal(i == n_sig - 1));
        sent += n_sig;
      end
    end
    wait_idle();
  endtask

  // receiver holds off while closing requests keep coming, input must stall
  task automatic test_backpressure();
    tx_gap_max = 0;
    rx_gap_max = 0;
    rx_hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) send_signal(random_signal(1'b1));
    for (int i = 0; i < 4; i++) send_signal(random_signal(i == 3));
    wait_idle();
  endtask

  // frame sink: per frame waits for valid, stalls a random count or the hold-off, then takes it
  initial begin : frame_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, rx_gap_max);
      end
      if (stall > 0) begin
        frame_ready <= 1'b0;
        do @(posedge clk); while (!frame_valid);
        repeat (stall) @(posedge clk);
      end
      frame_ready <= 1'b1;
      do @(posedge clk); while (!(frame_valid && frame_ready));
    end
  end

  // frame checker: every accepted frame against the oldest one due
  always @(posedge clk) begin
    sfp_pkg::frame_t want;
    if (!rst && frame_valid && frame_ready) begin
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("frame with none due, id %h", frame.frame_id));
      end else begin
        want = frames_due.pop_front();
        if (frame.frame_id !== want.frame_id) begin
          report_mismatch($sformatf("frame_id %h want %h", frame.frame_id, want.frame_id));
        end
        if (frame.frame_dlc !== want.frame_dlc) begin
          report_mismatch($sformatf("frame_dlc %h want %h", frame.frame_dlc, want.frame_dlc));
        end
        if (frame.frame_payload !== want.frame_payload) begin
          report_mismatch($sformatf("frame_payload %h want %h",
                                    frame.frame_payload, want.frame_payload));
        end
        if (frame.error_code !== want.error_code) begin
          report_mismatch($sformatf("error_code %0d want %0d",
                                    frame.error_code, want.error_code));
        end
      end
    end
  end

  // watchdog: too long without any handshake or register access ends the run
  always @(posedge clk) begin
    if (rst || (sig_valid && sig_ready) || (frame_valid && frame_ready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("signal_frame_packer regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_id_widths();
    test_backpressure();
    test_random();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("signal_frame_packer regression: pass");
    end else begin
      $display("signal_frame_packer regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sfp_pkg.sv
rtl/sfp_div.sv
rtl/sfp_pack.sv
rtl/signal_frame_packer.sv
verif/tb_top.sv
